@@ design/fsd_pkg.sv @@
// Shared types, constants and reset values of the frame spike and stall detector.
`timescale 1ns / 1ps

package fsd_pkg;

  localparam int unsigned FrameW = 24;
  localparam int unsigned StampW = 48;
  localparam int unsigned AvgW   = 40;
  localparam int unsigned RunW   = 16;
  localparam int unsigned MultW  = 8;
  localparam int unsigned CntW   = 8;
  localparam int unsigned CfgW   = 24;

  localparam logic [12:0] AlphaQ16 = 13'd6554;

  localparam logic [MultW-1:0]  SpikeMultRst = 8'd32;
  localparam logic [FrameW-1:0] SpikeMinRst  = 24'd2048;
  localparam logic [FrameW-1:0] SlowLimitRst = 24'd4267;
  localparam logic [CntW-1:0]   StallCntRst  = 8'd3;

  typedef enum logic [1:0] {
    EV_SPIKE       = 2'd0,
    EV_STALL_START = 2'd1,
    EV_STALL_END   = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    CFG_SPIKE_MULT = 2'd0,
    CFG_SPIKE_MIN  = 2'd1,
    CFG_SLOW_LIMIT = 2'd2,
    CFG_STALL_CNT  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [MultW-1:0]  spike_mult;
    logic [FrameW-1:0] spike_min;
    logic [FrameW-1:0] slow_limit;
    logic [CntW-1:0]   stall_cnt;
  } cfg_t;

  typedef struct packed {
    event_kind_e       kind;
    logic [FrameW-1:0] frame_time;
    logic [StampW-1:0] stamp;
    logic [RunW-1:0]   run;
    logic              last;
  } event_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] n;
    event_t     ev0;
    event_t     ev1;
  } evpush_t;

endpackage

@@ design/fsd_frame_if.sv @@
// Frame channel: one frame time and its timestamp per beat.
`timescale 1ns / 1ps

interface fsd_frame_if
  import fsd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FrameW-1:0] frame_time;
  logic [StampW-1:0] time_stamp;

  modport source (output valid, frame_time, time_stamp, input ready);
  modport sink   (input valid, frame_time, time_stamp, output ready);
endinterface

@@ design/fsd_event_if.sv @@
// Event channel: one spike or stall event per beat.
`timescale 1ns / 1ps

interface fsd_event_if
  import fsd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [FrameW-1:0] event_frame_time;
  logic [StampW-1:0] event_stamp;
  logic [RunW-1:0]   slow_run_length;
  logic              last_event;

  modport source (output valid, event_kind, event_frame_time, event_stamp,
                  slow_run_length, last_event, input ready);
  modport sink   (input valid, event_kind, event_frame_time, event_stamp,
                  slow_run_length, last_event, output ready);
endinterface

@@ design/fsd_track.sv @@
// Input register, running average, slow run tracking and event generation.
`timescale 1ns / 1ps

module fsd_track
  import fsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fsd_frame_if.sink   frame_i,
  input  cfg_t        cfg_i,
  input  logic [1:0]  space_i,
  output evpush_t     push_o
);

  logic              s1_valid_q;
  logic [FrameW-1:0] s1_ft_q;
  logic [StampW-1:0] s1_ts_q;
  logic [AvgW-1:0]   avg_q, avg_d;
  logic [RunW-1:0]   run_q, run_d;
  logic              stalled_q, stalled_d;

  logic [47:0] thresh;
  logic [52:0] prod_a;
  logic [36:0] prod_f;
  logic [56:0] sum;
  logic [RunW-1:0] run_inc;
  logic spike, slow, start, stop, stall_ev;
  logic [1:0] n;
  logic s1_fire;
  event_t ev_spike, ev_stall;

  assign s1_fire       = s1_valid_q && (n <= space_i);
  assign frame_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (frame_i.ready) begin
      s1_valid_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid && frame_i.ready) begin
      s1_ft_q <= frame_i.frame_time;
      s1_ts_q <= frame_i.time_stamp;
    end
  end

  assign thresh = 48'(avg_q) * 48'(cfg_i.spike_mult);
  assign spike  = ({4'b0, s1_ft_q, 20'b0} > thresh) && (s1_ft_q > cfg_i.spike_min);

  assign prod_a = 53'(avg_q) * 53'(AlphaQ16);
  assign prod_f = 37'(s1_ft_q) * 37'(AlphaQ16);
  assign sum    = {1'b0, avg_q, 16'b0} + {4'b0, prod_f, 16'b0} - {4'b0, prod_a};
  assign avg_d  = sum[55:16];

  assign slow     = s1_ft_q > cfg_i.slow_limit;
  assign run_inc  = (run_q == {RunW{1'b1}}) ? run_q : run_q + 16'd1;
  assign start    = slow && (run_inc == {8'b0, cfg_i.stall_cnt}) && !stalled_q;
  assign stop     = !slow && stalled_q;
  assign stall_ev = start || stop;
  assign run_d    = slow ? run_inc : '0;

  always_comb begin
    stalled_d = stalled_q;
    if (start) begin
      stalled_d = 1'b1;
    end else if (stop) begin
      stalled_d = 1'b0;
    end
  end

  always_comb begin
    ev_spike.kind       = EV_SPIKE;
    ev_spike.frame_time = s1_ft_q;
    ev_spike.stamp      = s1_ts_q;
    ev_spike.run        = '0;
    ev_spike.last       = !stall_ev;
    ev_stall.kind       = start ? EV_STALL_START : EV_STALL_END;
    ev_stall.frame_time = s1_ft_q;
    ev_stall.stamp      = s1_ts_q;
    ev_stall.run        = start ? run_inc : run_q;
    ev_stall.last       = 1'b1;
  end

  assign n = {1'b0, spike} + {1'b0, stall_ev};

  always_comb begin
    push_o.valid = s1_fire;
    push_o.n     = n;
    push_o.ev0   = spike ? ev_spike : ev_stall;
    push_o.ev1   = ev_stall;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q     <= '0;
      run_q     <= '0;
      stalled_q <= 1'b0;
    end else if (s1_fire) begin
      avg_q     <= avg_d;
      run_q     <= run_d;
      stalled_q <= stalled_d;
    end
  end

  a_stall_open_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stalled_q |-> run_q != '0)
    else $error("stall open with empty slow run");

  a_stall_start_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stalled_q) |-> run_q == {8'b0, $past(cfg_i.stall_cnt)})
    else $error("stall opened at wrong run length");

endmodule

@@ design/fsd_evbuf.sv @@
// Two-entry event result register feeding the event channel.
`timescale 1ns / 1ps

module fsd_evbuf
  import fsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  evpush_t     push_i,
  output logic [1:0]  space_o,
  fsd_event_if.source event_o
);

  event_t     slot_q [2];
  event_t     slot_d [2];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] rem;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && event_o.ready;
  assign rem     = cnt_q - {1'b0, pop};
  assign space_o = 2'd2 - rem;

  always_comb begin
    slot_d = slot_q;
    if (pop) begin
      slot_d[0] = slot_q[1];
    end
    if (push_i.valid) begin
      if (push_i.n != 2'd0) begin
        slot_d[rem[0]] = push_i.ev0;
      end
      if (push_i.n == 2'd2) begin
        slot_d[1] = push_i.ev1;
      end
    end
    cnt_d = rem + (push_i.valid ? push_i.n : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign event_o.valid            = cnt_q != 2'd0;
  assign event_o.event_kind       = slot_q[0].kind;
  assign event_o.event_frame_time = slot_q[0].frame_time;
  assign event_o.event_stamp      = slot_q[0].stamp;
  assign event_o.slow_run_length  = slot_q[0].run;
  assign event_o.last_event       = slot_q[0].last;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("event buffer overfilled");

  a_tail_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> slot_q[1].last)
    else $error("tail event not closing its frame");

  a_head_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) && !slot_q[0].last |-> cnt_q == 2'd2)
    else $error("first event of a pair without its partner");

endmodule

@@ design/frame_spike_stall_detector.sv @@
// Frame spike and stall detector top level: configuration registers and wiring.
// Takes one frame per clock cycle unless the input register is held. Each frame
// is held in the input register, where the spike test, the moving-average
// update and the slow run count are resolved and committed together, so a frame
// leaves the input register in the cycle after it arrives when the two-entry
// event buffer has room for all of its events. A frame raises zero, one or two
// events; the event channel drains one beat per cycle while ready is high, and
// a stalled output holds the input register.
`timescale 1ns / 1ps

module frame_spike_stall_detector
  import fsd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  fsd_frame_if.sink       frame_i,
  fsd_event_if.source     event_o
);

  cfg_t       cfg_q;
  evpush_t    push;
  logic [1:0] space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spike_mult <= SpikeMultRst;
      cfg_q.spike_min  <= SpikeMinRst;
      cfg_q.slow_limit <= SlowLimitRst;
      cfg_q.stall_cnt  <= StallCntRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SPIKE_MULT: cfg_q.spike_mult <= cfg_data_i[MultW-1:0];
        CFG_SPIKE_MIN:  cfg_q.spike_min  <= cfg_data_i;
        CFG_SLOW_LIMIT: cfg_q.slow_limit <= cfg_data_i;
        CFG_STALL_CNT:  cfg_q.stall_cnt  <= cfg_data_i[CntW-1:0];
      endcase
    end
  end

  fsd_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_i),
    .cfg_i   (cfg_q),
    .space_i (space),
    .push_o  (push)
  );

  fsd_evbuf u_evbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .event_o (event_o)
  );

endmodule
